[sv/tmu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmu_pkg
// Shared types, codes and the 32-bit clamp of the 4x4 transform unit.
// ----------------------------------------------------------------------------
package tmu_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [2:0] {
        FN_IDENT = 3'd0,
        FN_LOAD  = 3'd1,
        FN_STAGE = 3'd2,
        FN_MUL   = 3'd3,
        FN_QUAT  = 3'd4,
        FN_TRANS = 3'd5,
        FN_READ  = 3'd6
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUAT,
        ST_OPRD,
        ST_OPLD,
        ST_RUN,
        ST_DRAIN,
        ST_WB,
        ST_RD,
        ST_OUT
    } t_state;

    // One column of four 32-bit elements, row 0 in the low word.
    typedef logic [3:0][31:0] t_col;

    // Control of the multiply-accumulate lanes for one issued column read.
    typedef struct packed {
        logic       valid;
        logic       clr;
        logic       transpose;
        logic [1:0] k;
        logic [1:0] sel;
    } t_mac_ctl;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // Clamp to 32 bits; bit 32 of the result flags a clamp.
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < SAT_LO) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

[sv/transform_matrix_unit_4x4.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transform_matrix_unit_4x4
// 4x4 fixed-point transform unit: current and operand matrices in column
// memories, in-place multiply, quaternion rotation, transpose and read.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tuser {col, func}, tdata {val_3 .. val_0}
//  m_axis   | out       | tuser {saturated}, tdata {out_3 .. out_0}
//
// Identity, load, stage, read and the spare code 7 go straight to the column
// read and the output. Multiply and transpose build each of the four result
// columns in turn by operand read, operand load, memory read with the lane
// pipeline, drain and write-back, then do the final column read and output.
// Quaternion multiply first forms the ten products on the single shared multiplier.
// Reset is synchronous and active low; it restores identity and a zero
// operand through valid bits, with no clearing pass. The input is taken only
// between items; a result waiting on a stalled output does not block it.
// ----------------------------------------------------------------------------
module transform_matrix_unit_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // val_0, val_1, val_2, val_3
    input  logic [4:0]   s_axis_tuser,   // func[2:0], col[4:3]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_0, out_1, out_2, out_3
    output logic         m_axis_tuser    // saturated
);
    import tmu_pkg::*;

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    t_state     r_state, n_state;
    t_func      r_func;
    logic [1:0] r_colq;

    // The current matrix lives in two banks of four columns. Multiply and
    // transpose read one bank and write the other, then flip r_bank.
    logic [127:0] r_cmem [8];
    logic [127:0] r_omem [4];
    logic [7:0]   r_cvalid;
    logic [3:0]   r_ovld;
    logic         r_bank;

    logic [127:0] r_cmem_rd;
    logic         r_crd_vld;
    logic [1:0]   r_crd_col;
    logic [127:0] r_omem_rd;
    logic         r_ord_vld;

    logic [1:0] r_c;
    logic [1:0] r_k;
    logic       r_v1;
    logic [1:0] r_k1;
    t_col       r_rhs;
    logic       r_sat;

    logic [127:0] r_out;
    logic         r_osat;
    logic         r_ovalid;

    logic       s_accept;
    t_func      s_func;
    logic       cm_we, cm_re, om_we, om_re;
    logic [2:0] cm_waddr, cm_raddr;
    logic [127:0] cm_wdata;
    logic       q_start;
    t_col       s_crd;
    t_mac_ctl   mac_ctl;
    t_col       mac_col, q_col;
    logic       mac_sat, mac_busy, q_done, q_sat;
    logic       out_free;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign s_func    = t_func'(s_axis_tuser[2:0]);
    assign out_free  = !r_ovalid || m_axis_tready;

    // A column that was never written since identity or reset reads as the
    // identity column.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (r_crd_vld) begin
                s_crd[r] = r_cmem_rd[32*r +: 32];
            end else begin
                s_crd[r] = (r_crd_col == 2'(r)) ? ONE : 32'd0;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_func)
                        FN_MUL, FN_TRANS: n_state = ST_OPRD;
                        FN_QUAT:          n_state = ST_QUAT;
                        default:          n_state = ST_RD;
                    endcase
                end
            end
            ST_QUAT:  if (q_done) n_state = ST_OPRD;
            ST_OPRD:  n_state = ST_OPLD;
            ST_OPLD:  n_state = ST_RUN;
            ST_RUN:   if (r_k == 2'd3) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_v1 && !mac_busy) n_state = ST_WB;
            ST_WB:    n_state = (r_c == 2'd3) ? ST_RD : ST_OPRD;
            ST_RD:    n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs: memory ports and unit controls.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        cm_we    = 1'b0;
        cm_waddr = {r_bank, s_axis_tuser[4:3]};
        cm_wdata = s_axis_tdata;
        cm_re    = 1'b0;
        cm_raddr = {r_bank, r_colq};
        om_we    = 1'b0;
        om_re    = 1'b0;
        q_start  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    cm_we   = (s_func == FN_LOAD);
                    om_we   = (s_func == FN_STAGE);
                    q_start = (s_func == FN_QUAT);
                end
            end
            ST_OPRD: om_re = 1'b1;
            ST_RUN: begin
                cm_re    = 1'b1;
                cm_raddr = {r_bank, r_k};
            end
            ST_WB: begin
                cm_we    = 1'b1;
                cm_waddr = {~r_bank, r_c};
                cm_wdata = mac_col;
            end
            ST_RD:   cm_re = 1'b1;
            default: ;
        endcase
        mac_ctl.valid     = r_v1;
        mac_ctl.clr       = (r_state == ST_OPLD);
        mac_ctl.transpose = (r_func == FN_TRANS);
        mac_ctl.k         = r_k1;
        mac_ctl.sel       = r_c;
    end

    // Column memories.
    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            r_cmem[cm_waddr] <= cm_wdata;
        end
        if (cm_re) begin
            r_cmem_rd <= r_cmem[cm_raddr];
            r_crd_vld <= r_cvalid[cm_raddr];
            r_crd_col <= cm_raddr[1:0];
        end
        if (om_we) begin
            r_omem[s_axis_tuser[4:3]] <= s_axis_tdata;
        end
        if (om_re) begin
            r_omem_rd <= r_omem[r_c];
            r_ord_vld <= r_ovld[r_c];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cvalid <= '0;
            r_ovld   <= '0;
            r_bank   <= 1'b0;
            r_v1     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_RUN);
            if (cm_we) begin
                r_cvalid[cm_waddr] <= 1'b1;
            end
            if (om_we) begin
                r_ovld[s_axis_tuser[4:3]] <= 1'b1;
            end
            if (s_accept && (s_func == FN_IDENT)) begin
                r_cvalid <= '0;
            end
            if ((r_state == ST_WB) && (r_c == 2'd3)) begin
                r_bank <= ~r_bank;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func <= s_func;
            r_colq <= s_axis_tuser[4:3];
            r_sat  <= 1'b0;
            r_c    <= 2'd0;
        end
        r_k1 <= r_k;
        case (r_state)
            ST_OPLD: begin
                r_k <= 2'd0;
                if (r_func == FN_QUAT) begin
                    r_rhs <= q_col;
                    r_sat <= r_sat | q_sat;
                end else begin
                    r_rhs <= r_ord_vld ? r_omem_rd : '0;
                end
            end
            ST_RUN: r_k <= r_k + 2'd1;
            ST_WB: begin
                r_sat <= r_sat | mac_sat;
                r_c   <= r_c + 2'd1;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out  <= s_crd;
                    r_osat <= r_sat;
                end
            end
            default: ;
        endcase
    end

    tmu_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_data  (s_crd),
        .i_rhs   (r_rhs),
        .o_col   (mac_col),
        .o_sat   (mac_sat),
        .o_busy  (mac_busy)
    );

    tmu_quat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_q     (s_axis_tdata),
        .i_sel   (r_c),
        .o_done  (q_done),
        .o_col   (q_col),
        .o_sat   (q_sat)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_osat;

endmodule

[sv/tmu_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmu_mac
// Four multiply-accumulate lanes that build one result column.
// ----------------------------------------------------------------------------
module tmu_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmu_pkg::t_mac_ctl i_ctl,
    input  tmu_pkg::t_col     i_data,
    input  tmu_pkg::t_col     i_rhs,
    output tmu_pkg::t_col     o_col,
    output logic              o_sat,
    output logic              o_busy
);
    import tmu_pkg::*;

    localparam int AW = 66 - FRAC_BITS;

    logic                 r_v2;
    logic signed [63:0]   r_p   [4];
    logic signed [AW-1:0] r_acc [4];
    logic [32:0]          s_clamp [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.valid;
        end
    end

    // Stage one: a product per lane, or the moved element for a transpose.
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            for (int r = 0; r < 4; r++) begin
                if (i_ctl.transpose) begin
                    if (i_ctl.k == 2'(r)) begin
                        r_p[r] <= 64'($signed(i_data[i_ctl.sel])) <<< FRAC_BITS;
                    end else begin
                        r_p[r] <= '0;
                    end
                end else begin
                    r_p[r] <= $signed(i_data[r]) * $signed(i_rhs[i_ctl.k]);
                end
            end
        end
    end

    // Stage two: truncate toward minus infinity and add exactly.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            if (i_ctl.clr) begin
                r_acc[r] <= '0;
            end else if (r_v2) begin
                r_acc[r] <= r_acc[r] + AW'(r_p[r] >>> FRAC_BITS);
            end
        end
    end

    always_comb begin
        o_sat = 1'b0;
        for (int r = 0; r < 4; r++) begin
            s_clamp[r] = sat32(64'(r_acc[r]));
            o_col[r]   = s_clamp[r][31:0];
            o_sat      = o_sat | s_clamp[r][32];
        end
    end

    assign o_busy = r_v2;

endmodule

[sv/tmu_quat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmu_quat
// Forms the ten quaternion products with one multiplier and gives the
// selected column of the rotation matrix.
// ----------------------------------------------------------------------------
module tmu_quat #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tmu_pkg::t_col i_q,
    input  logic [1:0]    i_sel,
    output logic          o_done,
    output tmu_pkg::t_col o_col,
    output logic          o_sat
);
    import tmu_pkg::*;

    localparam int PW = 64 - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    // Product slots and quaternion components (w, x, y, z).
    localparam logic [3:0] P_WW = 4'd0, P_XX = 4'd1, P_YY = 4'd2, P_ZZ = 4'd3;
    localparam logic [3:0] P_XY = 4'd4, P_XZ = 4'd5, P_YZ = 4'd6;
    localparam logic [3:0] P_WX = 4'd7, P_WY = 4'd8, P_WZ = 4'd9;
    localparam logic [1:0] Q_W = 2'd0, Q_X = 2'd1, Q_Y = 2'd2, Q_Z = 2'd3;

    t_col                 r_q;
    logic                 r_run;
    logic [3:0]           r_step;
    logic                 r_pv;
    logic [3:0]           r_pidx;
    logic signed [63:0]   r_pr;
    logic signed [PW-1:0] r_prod [10];
    logic                 r_done;
    logic [1:0]           s_a, s_b;
    logic signed [SW-1:0] e [10];
    logic signed [SW-1:0] s_el [3];
    logic [32:0]          s_clamp [3];

    always_comb begin
        case (r_step)
            P_WW:    begin s_a = Q_W; s_b = Q_W; end
            P_XX:    begin s_a = Q_X; s_b = Q_X; end
            P_YY:    begin s_a = Q_Y; s_b = Q_Y; end
            P_ZZ:    begin s_a = Q_Z; s_b = Q_Z; end
            P_XY:    begin s_a = Q_X; s_b = Q_Y; end
            P_XZ:    begin s_a = Q_X; s_b = Q_Z; end
            P_YZ:    begin s_a = Q_Y; s_b = Q_Z; end
            P_WX:    begin s_a = Q_W; s_b = Q_X; end
            P_WY:    begin s_a = Q_W; s_b = Q_Y; end
            default: begin s_a = Q_W; s_b = Q_Z; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pv   <= r_run;
            r_done <= r_pv && (r_pidx == P_WZ);
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 4'd1;
                if (r_step == P_WZ) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_q;
        end
        if (r_run) begin
            r_pr   <= $signed(r_q[s_a]) * $signed(r_q[s_b]);
            r_pidx <= r_step;
        end
        if (r_pv) begin
            r_prod[r_pidx] <= PW'(r_pr >>> FRAC_BITS);
        end
    end

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            e[i] = SW'(r_prod[i]);
        end
        case (i_sel)
            2'd0: begin
                s_el[0] = e[P_WW] + e[P_XX] - e[P_YY] - e[P_ZZ];
                s_el[1] = (e[P_XY] <<< 1) + (e[P_WZ] <<< 1);
                s_el[2] = (e[P_XZ] <<< 1) - (e[P_WY] <<< 1);
            end
            2'd1: begin
                s_el[0] = (e[P_XY] <<< 1) - (e[P_WZ] <<< 1);
                s_el[1] = e[P_WW] - e[P_XX] + e[P_YY] - e[P_ZZ];
                s_el[2] = (e[P_YZ] <<< 1) + (e[P_WX] <<< 1);
            end
            2'd2: begin
                s_el[0] = (e[P_XZ] <<< 1) + (e[P_WY] <<< 1);
                s_el[1] = (e[P_YZ] <<< 1) - (e[P_WX] <<< 1);
                s_el[2] = e[P_WW] - e[P_XX] - e[P_YY] + e[P_ZZ];
            end
            default: begin
                s_el[0] = '0;
                s_el[1] = '0;
                s_el[2] = '0;
            end
        endcase
        o_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            s_clamp[r] = sat32(64'(s_el[r]));
            o_col[r]   = s_clamp[r][31:0];
            o_sat      = o_sat | s_clamp[r][32];
        end
        o_col[3] = (i_sel == 2'd3) ? ONE : 32'd0;
    end

    assign o_done = r_done;

endmodule

[sv/tmu_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmu_check
// Port-level checks of the transform unit, bound to the top level.
// ----------------------------------------------------------------------------
module tmu_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic [4:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // One item at a time: the input closes right after a transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input open while an item is in work");

    // A new result appears only at the end of an item's work.
    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without an item in work");

endmodule

bind transform_matrix_unit_4x4 tmu_check u_tmu_check (.*);
